// ----- src/vdi_pkg.sv -----
package vdi_pkg;

    localparam int MaxVertices = 1024;
    localparam int AttrsPerVertex = 8;
    localparam int VtxIdxW = $clog2(MaxVertices);
    localparam int AttrIdxW = $clog2(AttrsPerVertex);
    localparam int CountW = VtxIdxW + 1;
    localparam int MemAddrW = VtxIdxW + AttrIdxW;
    localparam int QueueDepth = 2;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_NORMALIZE = 2'd2;

    localparam int InDataW = 2 + 32 * AttrsPerVertex;
    localparam int InTdataW = ((InDataW + 7) / 8) * 8;
    localparam int OutDataW = 16 + 1 + 2 + 11 + 16;
    localparam int OutTdataW = ((OutDataW + 7) / 8) * 8;

    typedef logic signed [31:0] t_attr;

    // classified work item passed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        t_attr [AttrsPerVertex-1:0] attr;
    } t_job;

endpackage

// ----- src/vdi_front.sv -----
// Front: accepts items, normalises normals (shared 66-bit isqrt and a
// restoring divider, one bit per cycle), pushes classified jobs to the queue.
module vdi_front
    import vdi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_cmd,
    input  t_attr [AttrsPerVertex-1:0] i_attr,
    input  logic                  i_normalize,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job                  o_job
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_SQRT = 6'b000100,
        S_DIV  = 6'b001000,
        S_PUSH = 6'b010000,
        S_ACC  = 6'b100000
    } t_fstate;

    t_fstate r_state, n_state;
    t_job    r_job;
    logic [1:0]  r_k;
    logic [65:0] r_sum;
    logic [65:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_bit;
    logic [48:0] r_num;
    logic [49:0] r_drem;
    logic [48:0] r_quo;
    logic [5:0]  r_cnt;
    logic [31:0] w_mag;
    logic [63:0] w_sq;
    logic [67:0] w_trial;
    logic [67:0] w_rem4;
    logic [49:0] w_dsh;
    logic [49:0] w_quo_len;
    logic [31:0] w_q;

    assign w_mag = r_job.attr[3 + r_k][31] ? 32'(-r_job.attr[3 + r_k])
                                           : r_job.attr[3 + r_k];
    assign w_sq = 64'(w_mag) * 64'(w_mag);
    // digit-by-digit square root: two bits of the radicand per step
    assign w_rem4 = {r_rem, r_sum[65:64]};
    assign w_trial = {r_root, 2'b01};
    assign w_dsh = {r_drem[48:0], r_num[48]};
    assign w_quo_len = 50'(r_root);
    assign w_q = r_quo[31:0];

    assign o_ready = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job = r_job;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_ACC;
            S_ACC:  n_state = (r_job.cmd == CMD_ADD && i_normalize) ? S_SQ : S_PUSH;
            S_SQ:   if (r_k == 2'd2) n_state = S_SQRT;
            // a zero root means a zero normal, which is kept as it is
            S_SQRT: if (r_bit == 6'd0) n_state = (r_root == '0) ? S_PUSH : S_DIV;
            S_DIV:  if (r_cnt == 6'd50 && r_k == 2'd2) n_state = S_PUSH;
            S_PUSH: if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_job.cmd <= i_cmd;
                r_job.attr <= i_attr;
                r_k <= '0;
                r_sum <= '0;
            end
            S_ACC: ;
            S_SQ: begin
                r_sum <= r_sum + 66'(w_sq);
                r_k <= r_k + 2'd1;
                r_rem <= '0;
                r_root <= '0;
                r_bit <= 6'd33;
            end
            S_SQRT: begin
                if (r_bit != 6'd0) begin
                    if (w_rem4 >= w_trial) begin
                        r_rem <= 66'(w_rem4 - w_trial);
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem <= 66'(w_rem4);
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    r_sum <= {r_sum[63:0], 2'b00};
                    r_bit <= r_bit - 6'd1;
                end else begin
                    r_k <= '0;
                    r_cnt <= '0;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd0) begin
                    r_num <= {1'b0, w_mag, 16'd0} + 49'(r_root[32:1]);
                    r_drem <= '0;
                    r_quo <= '0;
                    r_cnt <= 6'd1;
                end else if (r_cnt != 6'd50) begin
                    if (w_dsh >= w_quo_len) begin
                        r_drem <= w_dsh - w_quo_len;
                        r_quo <= {r_quo[47:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh;
                        r_quo <= {r_quo[47:0], 1'b0};
                    end
                    r_num <= {r_num[47:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                end else begin
                    r_job.attr[3 + r_k] <= r_job.attr[3 + r_k][31] ? -$signed(w_q)
                                                                   : $signed(w_q);
                    r_k <= r_k + 2'd1;
                    r_cnt <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- src/vdi_queue.sv -----
module vdi_queue
    import vdi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job r_mem [QueueDepth];
    logic [$clog2(QueueDepth)-1:0] r_wp, r_rp;
    logic [$clog2(QueueDepth):0]   r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != ($clog2(QueueDepth)+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + ($clog2(QueueDepth)+1)'(w_push) - ($clog2(QueueDepth)+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- src/vdi_back.sv -----
// Back: linear search over the store, one attribute word read per cycle while reading a vertex.
module vdi_back
    import vdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    input  logic [15:0] i_capacity,
    input  logic [15:0] i_tolerance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_vertex_index,
    output logic        o_was_match,
    output logic [1:0]  o_status,
    output logic [10:0] o_unique_count,
    output logic [15:0] o_index_count
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_READ  = 5'b00010,
        B_CHECK = 5'b00100,
        B_WRITE = 5'b01000,
        B_OUT   = 5'b10000
    } t_bstate;

    t_bstate r_state;
    t_job    r_job;
    logic [31:0] r_mem [MaxVertices*AttrsPerVertex];
    logic [31:0] r_rd;
    logic [CountW-1:0] r_stored;
    logic [15:0] r_emitted;
    logic r_closed;
    logic [VtxIdxW-1:0] r_vi;
    logic [AttrIdxW-1:0] r_ai;
    logic r_rd_pend;
    logic r_ok;
    logic [15:0] r_oidx;
    logic r_omatch;
    logic [1:0] r_ost;
    logic [32:0] w_diff;
    logic [32:0] w_absd;
    logic w_within;
    logic [16:0] w_limit;
    logic w_full_store;
    logic w_last_vtx;

    assign w_diff = 33'($signed(r_rd)) - 33'(r_job.attr[r_ai - 1'b1]);
    assign w_absd = w_diff[32] ? -w_diff : w_diff;
    assign w_within = (w_absd <= 33'(i_tolerance));
    assign w_limit = (17'(i_capacity) < 17'(MaxVertices)) ? 17'(i_capacity) : 17'(MaxVertices);
    assign w_full_store = 17'(r_stored) >= w_limit;
    assign w_last_vtx = (CountW'(r_vi) + 1'b1 == r_stored);

    assign o_job_ready = (r_state == B_IDLE);
    assign o_valid = (r_state == B_OUT);
    assign o_vertex_index = r_oidx;
    assign o_was_match = r_omatch;
    assign o_status = r_ost;
    assign o_unique_count = 11'(r_stored);
    assign o_index_count = r_emitted;

    always_ff @(posedge i_clk) begin
        if (r_state == B_READ) r_rd <= r_mem[{r_vi, r_ai}];
        if (r_state == B_WRITE) r_mem[{r_stored[VtxIdxW-1:0], r_ai}] <= 32'(r_job.attr[r_ai]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_stored <= '0;
            r_emitted <= '0;
            r_closed <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_oidx <= '0;
                    r_omatch <= 1'b0;
                    r_ost <= ST_DONE;
                    r_vi <= '0;
                    r_ai <= '0;
                    r_ok <= 1'b1;
                    r_rd_pend <= 1'b0;
                    case (i_job.cmd)
                        CMD_CLEAR: begin
                            r_stored <= '0;
                            r_emitted <= '0;
                            r_closed <= 1'b0;
                            r_state <= B_OUT;
                        end
                        CMD_CLOSE: begin
                            r_closed <= 1'b1;
                            r_state <= B_OUT;
                        end
                        CMD_ADD: begin
                            if (r_closed) begin
                                r_ost <= ST_IGNORED;
                                r_state <= B_OUT;
                            end else if (r_stored == '0) begin
                                r_state <= B_CHECK;
                            end else begin
                                r_state <= B_READ;
                            end
                        end
                        default: r_state <= B_OUT;
                    endcase
                end
                B_READ: begin
                    // pipelined: compare the word read last cycle
                    if (r_rd_pend && !w_within) r_ok <= 1'b0;
                    r_rd_pend <= 1'b1;
                    r_ai <= r_ai + 1'b1;
                    if (r_ai == AttrIdxW'(AttrsPerVertex - 1)) r_state <= B_CHECK;
                end
                B_CHECK: begin
                    r_rd_pend <= 1'b0;
                    if (r_rd_pend && !(r_ok && w_within) && !w_last_vtx) begin
                        r_vi <= r_vi + 1'b1;
                        r_ai <= '0;
                        r_ok <= 1'b1;
                        r_state <= B_READ;
                    end else begin
                        r_ai <= '0;
                        if (r_emitted >= i_capacity) begin
                            r_ost <= ST_DROP;
                            r_state <= B_OUT;
                        end else if (r_rd_pend && r_ok && w_within) begin
                            r_oidx <= 16'(r_vi);
                            r_omatch <= 1'b1;
                            r_emitted <= r_emitted + 16'd1;
                            r_state <= B_OUT;
                        end else if (w_full_store) begin
                            r_ost <= ST_DROP;
                            r_state <= B_OUT;
                        end else begin
                            r_state <= B_WRITE;
                        end
                    end
                end
                B_WRITE: begin
                    r_ai <= r_ai + 1'b1;
                    if (r_ai == AttrIdxW'(AttrsPerVertex - 1)) begin
                        r_oidx <= 16'(r_stored);
                        r_stored <= r_stored + 1'b1;
                        r_emitted <= r_emitted + 16'd1;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: if (i_ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- src/vertex_dedup_indexer.sv -----
// Vertex welding index builder.
// Input stream s_axis: one transaction per command (add, clear, close) with
// eight Q16.16 attributes. Output stream m_axis: exactly one result per
// input transaction, in order. Config: write port, registers 0 capacity,
// 1 match tolerance, 2 normalise normals; write only while idle.
// Front stage takes one item at a time; with normalisation on it sums the
// squares of the normal, square-roots them (2 bits/cycle) and divides each
// component (1 bit/cycle). Back stage searches stored vertices, reading the
// 8 attribute words of each through a single read port, and writes 8 to append.
// A two-entry queue decouples front and back, so the front keeps taking
// items, until the queue is full, while the back searches or the receiver stalls on m_axis.
// Reset (synchronous, active low) empties the store counters, opens the
// batch and sets capacity 1024, tolerance 0, normalisation off. The
// attribute memory is not cleared; only entries of the current batch are read.
module vertex_dedup_indexer
    import vdi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cmd[1:0], pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [InTdataW-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // vertex_index[15:0], was_match, status[1:0], unique_count[10:0], index_count[15:0]
    output logic [OutTdataW-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_capacity;
    logic [15:0] r_tolerance;
    logic r_normalize;
    t_attr [AttrsPerVertex-1:0] w_attr;
    logic w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    t_job w_fjob, w_bjob;
    logic [15:0] w_vidx, w_icnt;
    logic w_match;
    logic [1:0] w_st;
    logic [10:0] w_ucnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'd1024;
            r_tolerance <= '0;
            r_normalize <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY:  r_capacity <= i_cfg_data;
                CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                CFG_NORMALIZE: r_normalize <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < AttrsPerVertex; g++) begin : g_attr
        assign w_attr[g] = s_axis_tdata[2 + 32*g +: 32];
    end

    vdi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[1:0]), .i_attr(w_attr), .i_normalize(r_normalize),
        .o_job_valid(w_fj_valid), .i_job_ready(w_fj_ready), .o_job(w_fjob)
    );

    vdi_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid), .o_ready(w_fj_ready), .i_job(w_fjob),
        .o_valid(w_bj_valid), .i_ready(w_bj_ready), .o_job(w_bjob)
    );

    vdi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_bj_valid), .o_job_ready(w_bj_ready), .i_job(w_bjob),
        .i_capacity(r_capacity), .i_tolerance(r_tolerance),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_vertex_index(w_vidx), .o_was_match(w_match), .o_status(w_st),
        .o_unique_count(w_ucnt), .o_index_count(w_icnt)
    );

    assign m_axis_tdata = OutTdataW'({w_icnt, w_ucnt, w_st, w_match, w_vidx});

endmodule

// ----- src/vdi_checker.sv -----
module vdi_checker
    import vdi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OutTdataW-1:0] m_axis_tdata
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:17] == ST_DONE || m_axis_tdata[18:17] == ST_DROP
                           || m_axis_tdata[18:17] == ST_IGNORED))
        else $error("bad status code");

    a_drop_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[18:17] != ST_DONE) |-> m_axis_tdata[16:0] == '0)
        else $error("dropped item carries an index");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_match_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |->
            m_axis_tdata[15:0] < 16'(m_axis_tdata[29:19]))
        else $error("match index beyond stored count");

    // the front takes one transaction at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while the front is busy");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
